// ===== design/prism_containment_test_core_assert.svh =====
// Assertion macros for the containment test core.
`ifndef PRISM_CONTAINMENT_TEST_CORE_ASSERT_SVH
`define PRISM_CONTAINMENT_TEST_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PCT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pct_pkg.sv =====
`default_nettype none

package pct_pkg;

  localparam int MAX_VERTICES_DEF = 8;
  localparam int COORD_W          = 24;
  localparam int IDX_W            = 3;
  localparam int VCOUNT_W         = 4;
  localparam int DIFF_W           = COORD_W + 1;
  localparam int PROD_W           = 2 * DIFF_W;
  localparam int APB_AW           = 4;
  localparam int APB_DW           = 32;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = VCOUNT_W'(8);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_VERTEX_COUNT = 2'd0,
    REG_DEPTH_TOP    = 2'd1,
    REG_DEPTH_BOTTOM = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [VCOUNT_W-1:0] vertex_count;
    coord_t              depth_top;
    coord_t              depth_bottom;
  } cfg_t;

  // Word travelling down the cell chain.
  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] index;
    coord_t           px;
    coord_t           py;
    logic             depth_ok;
    logic             parity;
    logic             has_prev;
    coord_t           prev_x;
    coord_t           prev_y;
    coord_t           first_x;
    coord_t           first_y;
  } tok_t;

endpackage

`default_nettype wire

// ===== design/pct_if.sv =====
`default_nettype none

interface pct_in_if import pct_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_e            kind;
  logic [IDX_W-1:0] vertex_index;
  coord_t           coord_x;
  coord_t           coord_y;
  coord_t           coord_z;

  modport source (output valid, kind, vertex_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, kind, vertex_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface pct_out_if import pct_pkg::*; ();
  logic valid;
  logic ready;
  logic contained;
  logic in_outline;
  logic within_depth;

  modport source (output valid, contained, in_outline, within_depth, input ready);
  modport sink   (input valid, contained, in_outline, within_depth, output ready);
endinterface

`default_nettype wire

// ===== design/prism_containment_test_core.sv =====
// Polygon-and-slab containment test core.
//
// Input channel in_i carries one word per item: kind selects a vertex load
// (vertex_index, coord_x, coord_y) or a point query (coord_x, coord_y,
// coord_z). A load gives no result; a query gives one result word on out_o
// with in_outline (odd crossing count), within_depth (bottom < z < top) and
// contained (both). Results leave in input order.
// Registers (APB, 4-byte stride): vertex_count at 0x0, depth_top at 0x4,
// depth_bottom at 0x8. Write them only while the core is empty.
// Pipeline: a query passes the chain of vertex cells, two stages each
// (product, then compare), and then the closing-edge test, built the same way.
// Throughput: one word per cycle while no result is stalled on out_o.
// Loads travel the same chain and write their cell on the way, so every
// query sees exactly the loads accepted before it.
// Stall: while a result waits on out_o with ready low, the whole chain holds
// and in_i.ready drops; it resumes the cycle the result is taken.
// Reset: chain valid bits clear, vertex_count returns to 8 and both depth
// bounds to 0. Vertex storage is not cleared.
`default_nettype none

`include "prism_containment_test_core_assert.svh"

module prism_containment_test_core import pct_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  pct_in_if.sink                 in_i,
  pct_out_if.source              out_o
);

  localparam int CntW = $clog2(MAX_VERTICES + 1);

  cfg_t                  cfg;
  logic [CntW-1:0]       n_eff;
  logic                  adv;
  logic [MAX_VERTICES:0] vld;
  tok_t                  tok [MAX_VERTICES+1];
  logic                  fin_vld;
  tok_t                  fin_tok;
  logic                  close_eval;

  pct_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Saturate the vertex count to the number of cells.
  assign n_eff = (int'(cfg.vertex_count) > MAX_VERTICES) ? CntW'(MAX_VERTICES)
                                                         : CntW'(cfg.vertex_count);

  // Advance the whole chain unless a finished result is held.
  assign adv        = !out_o.valid || out_o.ready;
  assign in_i.ready = adv;

  // Build the entry word; the depth test needs only the registers.
  assign vld[0] = in_i.valid;
  always_comb begin
    tok[0]          = '0;
    tok[0].kind     = in_i.kind;
    tok[0].index    = in_i.vertex_index;
    tok[0].px       = in_i.coord_x;
    tok[0].py       = in_i.coord_y;
    tok[0].depth_ok = (in_i.coord_z < cfg.depth_top) && (in_i.coord_z > cfg.depth_bottom);
    tok[0].parity   = 1'b0;
    tok[0].has_prev = 1'b0;
  end

  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    pct_cell #(
      .MaxVertices (MAX_VERTICES),
      .CellIdx     (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .n_i     (n_eff),
      .valid_i (vld[k]),
      .tok_i   (tok[k]),
      .valid_o (vld[k+1]),
      .tok_o   (tok[k+1])
    );
  end

  // Closing edge: last active vertex back to vertex 0.
  assign close_eval = vld[MAX_VERTICES] && (tok[MAX_VERTICES].kind == KIND_QUERY)
                   && tok[MAX_VERTICES].has_prev;

  pct_edge u_close (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vld[MAX_VERTICES]),
    .tok_i   (tok[MAX_VERTICES]),
    .eval_i  (close_eval),
    .ax_i    (tok[MAX_VERTICES].prev_x),
    .ay_i    (tok[MAX_VERTICES].prev_y),
    .bx_i    (tok[MAX_VERTICES].first_x),
    .by_i    (tok[MAX_VERTICES].first_y),
    .valid_o (fin_vld),
    .tok_o   (fin_tok)
  );

  // Only queries leave the core; loads drop off at the end of the chain.
  assign out_o.valid        = fin_vld && (fin_tok.kind == KIND_QUERY);
  assign out_o.in_outline   = fin_tok.parity;
  assign out_o.within_depth = fin_tok.depth_ok;
  assign out_o.contained    = fin_tok.parity && fin_tok.depth_ok;

  `PCT_ASSERT_IMPL(a_stall_blocks_input, clk_i, rst_ni,
    out_o.valid && !out_o.ready, !in_i.ready, "input taken while result stalled")

  `PCT_ASSERT_NEXT(a_stall_holds_chain, clk_i, rst_ni,
    !adv, $stable(vld[MAX_VERTICES:1]) && $stable(fin_vld), "chain moved during stall")

endmodule

`default_nettype wire

// ===== design/pct_regs.sv =====
`default_nettype none

module pct_regs import pct_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e sel;
  logic     wr_en;

  assign sel    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (sel)
        REG_VERTEX_COUNT: cfg_d.vertex_count = pwdata[VCOUNT_W-1:0];
        REG_DEPTH_TOP:    cfg_d.depth_top    = coord_t'(pwdata[COORD_W-1:0]);
        REG_DEPTH_BOTTOM: cfg_d.depth_bottom = coord_t'(pwdata[COORD_W-1:0]);
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_VERTEX_COUNT: prdata = APB_DW'(cfg_q.vertex_count);
      REG_DEPTH_TOP:    prdata = APB_DW'(cfg_q.depth_top);
      REG_DEPTH_BOTTOM: prdata = APB_DW'(cfg_q.depth_bottom);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vertex_count <= VCOUNT_RST;
      cfg_q.depth_top    <= '0;
      cfg_q.depth_bottom <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pct_edge.sv =====
`default_nettype none

// Two-stage edge crossing test: products, then compare and parity update.
module pct_edge import pct_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   en_i,
  input  wire logic   valid_i,
  input  wire tok_t   tok_i,
  input  wire logic   eval_i,
  input  wire coord_t ax_i,
  input  wire coord_t ay_i,
  input  wire coord_t bx_i,
  input  wire coord_t by_i,
  output logic        valid_o,
  output tok_t        tok_o
);

  logic signed [DIFF_W-1:0] dy, dxp, dyp, dxe;
  logic signed [PROD_W-1:0] lhs_d, rhs_d, lhs_q, rhs_q;
  logic                     cnt_d, cnt_q, dpos_d, dpos_q;
  logic                     vld1_q, vld2_q;
  tok_t                     tok1_q, tok2_q, tok2_d;
  logic                     hit;

  assign dy  = DIFF_W'(by_i) - DIFF_W'(ay_i);
  assign dxp = DIFF_W'(tok_i.px) - DIFF_W'(ax_i);
  assign dyp = DIFF_W'(tok_i.py) - DIFF_W'(ay_i);
  assign dxe = DIFF_W'(bx_i) - DIFF_W'(ax_i);

  assign lhs_d  = PROD_W'(dxp) * PROD_W'(dy);
  assign rhs_d  = PROD_W'(dyp) * PROD_W'(dxe);
  assign dpos_d = by_i > ay_i;

  // Drop horizontal edges and edges wholly below or at/above the point.
  assign cnt_d = eval_i && (ay_i != by_i)
              && !((tok_i.py <= ay_i) && (tok_i.py <= by_i))
              && !((tok_i.py > ay_i) && (tok_i.py > by_i));

  assign hit = cnt_q && (dpos_q ? (lhs_q < rhs_q) : (lhs_q > rhs_q));

  always_comb begin
    tok2_d        = tok1_q;
    tok2_d.parity = tok1_q.parity ^ hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tok1_q <= tok_i;
      lhs_q  <= lhs_d;
      rhs_q  <= rhs_d;
      cnt_q  <= cnt_d;
      dpos_q <= dpos_d;
      tok2_q <= tok2_d;
    end
  end

  assign valid_o = vld2_q;
  assign tok_o   = tok2_q;

endmodule

`default_nettype wire

// ===== design/pct_cell.sv =====
`default_nettype none

// One polygon vertex: holds it, loads it from a passing load word and, if it is
// within the vertex count, tests the edge from the previous vertex for a query.
module pct_cell import pct_pkg::*; #(
  parameter int MaxVertices = MAX_VERTICES_DEF,
  parameter int CellIdx     = 0,
  localparam int CntW       = $clog2(MaxVertices + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [CntW-1:0] n_i,
  input  wire logic            valid_i,
  input  wire tok_t            tok_i,
  output logic                 valid_o,
  output tok_t                 tok_o
);

  coord_t own_x_q, own_y_q, own_x_d, own_y_d;
  logic   wr_en, active, eval;
  tok_t   tok_mod;

  assign wr_en   = en_i && valid_i && (tok_i.kind == KIND_LOAD)
                && (int'(tok_i.index) == CellIdx);
  assign own_x_d = tok_i.px;
  assign own_y_d = tok_i.py;

  assign active = valid_i && (tok_i.kind == KIND_QUERY) && (CellIdx < int'(n_i));
  assign eval   = active && tok_i.has_prev;

  always_comb begin
    tok_mod = tok_i;
    if (active) begin
      tok_mod.prev_x   = own_x_q;
      tok_mod.prev_y   = own_y_q;
      tok_mod.has_prev = 1'b1;
      if (!tok_i.has_prev) begin
        tok_mod.first_x = own_x_q;
        tok_mod.first_y = own_y_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      own_x_q <= own_x_d;
      own_y_q <= own_y_d;
    end
  end

  pct_edge u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .tok_i   (tok_mod),
    .eval_i  (eval),
    .ax_i    (tok_i.prev_x),
    .ay_i    (tok_i.prev_y),
    .bx_i    (own_x_q),
    .by_i    (own_y_q),
    .valid_o (valid_o),
    .tok_o   (tok_o)
  );

endmodule

`default_nettype wire
